[sv/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, constants and arithmetic helpers shared by the barometric
// compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int QDEPTH    = 4;
   localparam int QPW       = $clog2(QDEPTH);
   localparam int QCW       = $clog2(QDEPTH + 1);
   localparam int DIV_STEPS = 64;
   localparam int DEN_W     = 31;
   localparam int PRE_STG   = 12;
   localparam int POST_STG  = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ONLINE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_CALIB = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_LAST = 3'd4;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_OFFLINE = 2'd1,
      ST_CALIB   = 2'd2,
      ST_ZERODIV = 2'd3
   } bsc_status_type;

   typedef struct packed {
      logic [19:0] press_code;
      logic [19:0] temp_code;
   } bsc_req_type;

   typedef struct packed {
      logic signed [15:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      bsc_status_type     status;
   } bsc_rsp_type;

   typedef struct packed {
      logic [19:0]    praw;
      logic [19:0]    traw;
      bsc_status_type st;
   } bsc_item_type;

   typedef struct packed {
      logic [19:0]        praw;
      logic signed [15:0] tc;
      bsc_status_type     st;
      logic               neg;
   } bsc_meta_type;

   typedef struct packed {
      logic [15:0] plast;
      logic [63:0] phi;
      logic [63:0] plo;
      logic [47:0] tcal;
   } bsc_calib_type;

   // low 64 bits of a 64x64 product, split in 32x32 partial products
   typedef struct packed {
      logic [63:0] ll;
      logic [31:0] cr;
   } bsc_wm_type;

   function automatic bsc_wm_type wm_part(logic [63:0] a, logic [63:0] b);
      bsc_wm_type  r;
      logic [63:0] lh;
      logic [63:0] hl;
      r.ll = {32'b0, a[31:0]} * {32'b0, b[31:0]};
      lh   = {32'b0, a[31:0]} * {32'b0, b[63:32]};
      hl   = {32'b0, a[63:32]} * {32'b0, b[31:0]};
      r.cr = lh[31:0] + hl[31:0];
      return r;
   endfunction

   function automatic logic [63:0] wm_sum(bsc_wm_type p);
      return p.ll + {p.cr, 32'b0};
   endfunction

endpackage

[sv/bsc_front.sv]
// ----------------------------------------------------------------------------
// bsc_front
// Input stage: takes a reading and tags it with its error class.
// ----------------------------------------------------------------------------
module bsc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bsc_pkg::bsc_req_type  req_data,
   input  logic                  online,
   input  logic [15:0]           t1,
   output logic                  q_valid,
   input  logic                  q_ready,
   output bsc_pkg::bsc_item_type q_data
);

   logic                  f_vld_ff;
   logic                  f_vld_in;
   bsc_pkg::bsc_item_type f_item_ff;
   bsc_pkg::bsc_item_type f_item_in;
   logic                  take;

   assign req_ready = !f_vld_ff || q_ready;
   assign take      = req_valid && req_ready;
   assign f_vld_in  = take || (f_vld_ff && !q_ready);

   always_comb begin
      f_item_in.praw = req_data.press_code;
      f_item_in.traw = req_data.temp_code;
      if (!online) begin
         f_item_in.st = bsc_pkg::ST_OFFLINE;
      end else if (t1 == 16'd0) begin
         f_item_in.st = bsc_pkg::ST_CALIB;
      end else begin
         f_item_in.st = bsc_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= f_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         f_item_ff <= f_item_in;
      end
   end

   assign q_valid = f_vld_ff;
   assign q_data  = f_item_ff;

endmodule

[sv/bsc_fifo.sv]
// ----------------------------------------------------------------------------
// bsc_fifo
// Short queue between the input stage and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module bsc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bsc_pkg::bsc_item_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bsc_pkg::bsc_item_type out_data
);

   bsc_pkg::bsc_item_type         mem_ff [bsc_pkg::QDEPTH];
   logic [bsc_pkg::QPW-1:0]       wp_ff;
   logic [bsc_pkg::QPW-1:0]       wp_in;
   logic [bsc_pkg::QPW-1:0]       rp_ff;
   logic [bsc_pkg::QPW-1:0]       rp_in;
   logic [bsc_pkg::QCW-1:0]       cnt_ff;
   logic [bsc_pkg::QCW-1:0]       cnt_in;
   logic                          push;
   logic                          pop;

   assign in_ready  = cnt_ff != bsc_pkg::QCW'(bsc_pkg::QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= bsc_pkg::QCW'(bsc_pkg::QDEPTH))
      else $error("queue count out of range");

   a_cnt_up : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not follow push");

endmodule

[sv/bsc_div.sv]
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [63:0]                 in_num,
   input  logic [bsc_pkg::DEN_W-1:0]   in_den,
   input  bsc_pkg::bsc_meta_type       in_meta,
   output logic                        out_vld,
   output logic [63:0]                 out_quo,
   output bsc_pkg::bsc_meta_type       out_meta
);

   localparam int N = bsc_pkg::DIV_STEPS;
   localparam int W = bsc_pkg::DEN_W;

   logic                  vld_ff  [N];
   logic                  vld_in  [N];
   logic [W-1:0]          rem_ff  [N];
   logic [W-1:0]          rem_in  [N];
   logic [63:0]           wrd_ff  [N];
   logic [63:0]           wrd_in  [N];
   logic [W-1:0]          den_ff  [N];
   logic [W-1:0]          den_in  [N];
   bsc_pkg::bsc_meta_type meta_ff [N];
   bsc_pkg::bsc_meta_type meta_in [N];
   logic [W:0]            rs      [N];
   logic                  qb      [N];

   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            vld_in[k]  = in_vld;
            rs[k]      = {{W{1'b0}}, in_num[63]};
            wrd_in[k]  = in_num;
            den_in[k]  = in_den;
            meta_in[k] = in_meta;
         end else begin
            vld_in[k]  = vld_ff[k-1];
            rs[k]      = {rem_ff[k-1], wrd_ff[k-1][63]};
            wrd_in[k]  = wrd_ff[k-1];
            den_in[k]  = den_ff[k-1];
            meta_in[k] = meta_ff[k-1];
         end
         qb[k]     = rs[k] >= {1'b0, den_in[k]};
         rem_in[k] = qb[k] ? W'(rs[k] - {1'b0, den_in[k]}) : W'(rs[k]);
         wrd_in[k] = {wrd_in[k][62:0], qb[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < N; k++) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k]  <= rem_in[k];
            wrd_ff[k]  <= wrd_in[k];
            den_ff[k]  <= den_in[k];
            meta_ff[k] <= meta_in[k];
         end
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_quo  = wrd_ff[N-1];
   assign out_meta = meta_ff[N-1];

endmodule

[sv/bsc_back.sv]
// ----------------------------------------------------------------------------
// bsc_back
// Compensation pipeline: temperature, pressure terms, divide, final scaling.
// ----------------------------------------------------------------------------
module bsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bsc_pkg::bsc_item_type in_data,
   input  bsc_pkg::bsc_calib_type cal,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bsc_pkg::bsc_rsp_type  rsp_data
);

   localparam int NP = bsc_pkg::PRE_STG;
   localparam int NQ = bsc_pkg::POST_STG;

   logic [15:0]        t1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [15:0]        p1;

   assign t1 = cal.tcal[15:0];
   assign t2 = $signed(cal.tcal[31:16]);
   assign t3 = $signed(cal.tcal[47:32]);
   assign p1 = cal.plo[15:0];
   assign p2 = $signed(cal.plo[31:16]);
   assign p3 = $signed(cal.plo[47:32]);
   assign p4 = $signed(cal.plo[63:48]);
   assign p5 = $signed(cal.phi[15:0]);
   assign p6 = $signed(cal.phi[31:16]);
   assign p7 = $signed(cal.phi[47:32]);
   assign p8 = $signed(cal.phi[63:48]);
   assign p9 = $signed(cal.plast);

   logic en;
   logic out_vld_ff, out_vld_in;
   bsc_pkg::bsc_rsp_type out_ff, out_in;

   assign en        = !out_vld_ff || rsp_ready;
   assign in_ready  = en;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   logic [NP-1:0] pv_ff, pv_in;
   logic [NQ-1:0] qv_ff, qv_in;
   bsc_pkg::bsc_meta_type pm_ff [NP];
   bsc_pkg::bsc_meta_type pm_in [NP];
   bsc_pkg::bsc_meta_type qm_ff [NQ];
   bsc_pkg::bsc_meta_type qm_in [NQ];

   // temperature
   logic signed [17:0] ta;
   logic signed [16:0] dt;
   logic signed [33:0] s0_ma_ff, s0_ma_in, s0_dd_ff, s0_dd_in;
   logic signed [21:0] ddt;
   logic signed [22:0] s1_at_ff, s1_at_in;
   logic signed [37:0] s1_mb_ff, s1_mb_in;
   logic signed [25:0] s2_tf_ff, s2_tf_in;
   logic signed [28:0] t5, tcw;
   logic signed [15:0] tc;
   logic signed [26:0] s3_x_ff, s3_x_in;
   // pressure terms
   logic signed [53:0] s4_xx_ff, s4_xx_in;
   logic signed [42:0] s4_x5_ff, s4_x5_in, s4_x2_ff, s4_x2_in;
   bsc_pkg::bsc_wm_type s5_w6_ff, s5_w6_in, s5_w3_ff, s5_w3_in;
   logic signed [42:0] s5_x5_ff, s5_x2_ff, s6_x5_ff, s6_x2_ff;
   logic [63:0] s6_v6_ff, s6_v6_in, s6_v3_ff, s6_v3_in;
   logic [63:0] s7_b1_ff, s7_b1_in, s7_a2_ff, s7_a2_in;
   bsc_pkg::bsc_wm_type s8_w1_ff, s8_w1_in;
   logic [63:0] s8_n0_ff, s8_n0_in;
   logic [20:0] pr;
   logic [63:0] s9_pd_ff, s9_pd_in;
   bsc_pkg::bsc_wm_type s9_wn_ff, s9_wn_in;
   logic [bsc_pkg::DEN_W-1:0] s10_v1_ff, s10_v1_in;
   logic [63:0] s10_nm_ff, s10_nm_in;
   logic [63:0] s11_nm_ff, s11_nm_in;
   logic [bsc_pkg::DEN_W-1:0] s11_dm_ff, s11_dm_in;
   // divider
   logic        d_vld;
   logic [63:0] d_quo;
   bsc_pkg::bsc_meta_type d_meta;
   // final terms
   logic [63:0] q0_p_ff, q0_p_in;
   logic [63:0] x13;
   logic [63:0] q1_p_ff, q1_x_ff, q1_x_in;
   bsc_pkg::bsc_wm_type q1_w9_ff, q1_w9_in, q1_w8_ff, q1_w8_in;
   logic [63:0] q2_p_ff, q2_x_ff, q2_y_ff, q2_y_in, q2_pb_ff, q2_pb_in;
   logic [63:0] q3_p_ff, q3_b2_ff, q3_b2_in;
   bsc_pkg::bsc_wm_type q3_wy_ff, q3_wy_in;
   logic [63:0] q4_p_ff, q4_b2_ff, q4_a3_ff, q4_a3_in;
   logic [63:0] q5_s_ff, q5_s_in;
   logic [63:0] pf;

   always_comb begin
      pv_in = {pv_ff[NP-2:0], in_valid};
      qv_in = {qv_ff[NQ-2:0], d_vld};
      out_vld_in = qv_ff[NQ-1];

      for (int k = 1; k < NP; k++) begin
         pm_in[k] = pm_ff[k-1];
      end
      for (int k = 1; k < NQ; k++) begin
         qm_in[k] = qm_ff[k-1];
      end

      // P0
      pm_in[0].praw = in_data.praw;
      pm_in[0].tc   = '0;
      pm_in[0].st   = in_data.st;
      pm_in[0].neg  = 1'b0;
      ta = $signed({1'b0, in_data.traw[19:3]}) - $signed({1'b0, t1, 1'b0});
      dt = $signed({1'b0, in_data.traw[19:4]}) - $signed({1'b0, t1});
      s0_ma_in = ta * t2;
      s0_dd_in = dt * dt;
      // P1
      ddt      = 22'(s0_dd_ff >>> 12);
      s1_at_in = 23'(s0_ma_ff >>> 11);
      s1_mb_in = ddt * t3;
      // P2
      s2_tf_in = 26'(s1_at_ff) + 26'(s1_mb_ff >>> 14);
      // P3
      t5  = 29'(s2_tf_ff) * 29'sd5 + 29'sd128;
      tcw = t5 >>> 8;
      if (tcw < -29'sd32768) begin
         tc = -16'sd32768;
      end else if (tcw > 29'sd32767) begin
         tc = 16'sd32767;
      end else begin
         tc = 16'(tcw);
      end
      pm_in[3].tc = tc;
      s3_x_in = 27'(s2_tf_ff) - 27'sd128000;
      // P4
      s4_xx_in = s3_x_ff * s3_x_ff;
      s4_x5_in = s3_x_ff * p5;
      s4_x2_in = s3_x_ff * p2;
      // P5
      s5_w6_in = bsc_pkg::wm_part(64'(s4_xx_ff), 64'(p6));
      s5_w3_in = bsc_pkg::wm_part(64'(s4_xx_ff), 64'(p3));
      // P6
      s6_v6_in = bsc_pkg::wm_sum(s5_w6_ff);
      s6_v3_in = bsc_pkg::wm_sum(s5_w3_ff);
      // P7
      s7_b1_in = s6_v6_ff + (64'(s6_x5_ff) << 17) + (64'(p4) << 35);
      s7_a2_in = 64'($signed(s6_v3_ff) >>> 8) + (64'(s6_x2_ff) << 12)
                 + 64'h0000_8000_0000_0000;
      // P8
      pr       = 21'h10_0000 - {1'b0, pm_ff[7].praw};
      s8_w1_in = bsc_pkg::wm_part(s7_a2_ff, {48'b0, p1});
      s8_n0_in = ({43'b0, pr} << 31) - s7_b1_ff;
      // P9
      s9_pd_in = bsc_pkg::wm_sum(s8_w1_ff);
      s9_wn_in = bsc_pkg::wm_part(s8_n0_ff, 64'd3125);
      // P10
      s10_v1_in = s9_pd_ff[63:33];
      s10_nm_in = bsc_pkg::wm_sum(s9_wn_ff);
      if (pm_ff[9].st == bsc_pkg::ST_OK && s10_v1_in == '0) begin
         pm_in[10].st = bsc_pkg::ST_ZERODIV;
      end
      // P11
      s11_nm_in = s10_nm_ff[63] ? 64'(-s10_nm_ff) : s10_nm_ff;
      s11_dm_in = s10_v1_ff[bsc_pkg::DEN_W-1] ? bsc_pkg::DEN_W'(-s10_v1_ff) : s10_v1_ff;
      pm_in[11].neg = s10_nm_ff[63] ^ s10_v1_ff[bsc_pkg::DEN_W-1];
      // Q0
      qm_in[0] = d_meta;
      q0_p_in  = d_meta.neg ? 64'(-d_quo) : d_quo;
      // Q1
      x13      = 64'($signed(q0_p_ff) >>> 13);
      q1_x_in  = x13;
      q1_w9_in = bsc_pkg::wm_part(64'(p9), x13);
      q1_w8_in = bsc_pkg::wm_part(64'(p8), q0_p_ff);
      // Q2
      q2_y_in  = bsc_pkg::wm_sum(q1_w9_ff);
      q2_pb_in = bsc_pkg::wm_sum(q1_w8_ff);
      // Q3
      q3_wy_in = bsc_pkg::wm_part(q2_y_ff, q2_x_ff);
      q3_b2_in = 64'($signed(q2_pb_ff) >>> 19);
      // Q4
      q4_a3_in = 64'($signed(bsc_pkg::wm_sum(q3_wy_ff)) >>> 25);
      // Q5
      q5_s_in = q4_p_ff + q4_a3_ff + q4_b2_ff;
      // output
      pf = 64'($signed(q5_s_ff) >>> 8) + (64'(p7) << 4);
      out_in.status            = qm_ff[NQ-1].st;
      out_in.temperature_centi = '0;
      out_in.pressure_q24_8    = '0;
      case (qm_ff[NQ-1].st)
         bsc_pkg::ST_OK: begin
            out_in.temperature_centi = qm_ff[NQ-1].tc;
            if (pf[63]) begin
               out_in.pressure_q24_8 = '0;
            end else if (pf[63:32] != '0) begin
               out_in.pressure_q24_8 = '1;
            end else begin
               out_in.pressure_q24_8 = pf[31:0];
            end
         end
         bsc_pkg::ST_ZERODIV: begin
            out_in.temperature_centi = qm_ff[NQ-1].tc;
         end
         default: begin
            out_in.temperature_centi = '0;
         end
      endcase
   end

   bsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (pv_ff[NP-1]),
      .in_num   (s11_nm_ff),
      .in_den   (s11_dm_ff),
      .in_meta  (pm_ff[NP-1]),
      .out_vld  (d_vld),
      .out_quo  (d_quo),
      .out_meta (d_meta)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff      <= '0;
         qv_ff      <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         pv_ff      <= pv_in;
         qv_ff      <= qv_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NP; k++) begin
            pm_ff[k] <= pm_in[k];
         end
         for (int k = 0; k < NQ; k++) begin
            qm_ff[k] <= qm_in[k];
         end
         s0_ma_ff  <= s0_ma_in;
         s0_dd_ff  <= s0_dd_in;
         s1_at_ff  <= s1_at_in;
         s1_mb_ff  <= s1_mb_in;
         s2_tf_ff  <= s2_tf_in;
         s3_x_ff   <= s3_x_in;
         s4_xx_ff  <= s4_xx_in;
         s4_x5_ff  <= s4_x5_in;
         s4_x2_ff  <= s4_x2_in;
         s5_w6_ff  <= s5_w6_in;
         s5_w3_ff  <= s5_w3_in;
         s5_x5_ff  <= s4_x5_ff;
         s5_x2_ff  <= s4_x2_ff;
         s6_v6_ff  <= s6_v6_in;
         s6_v3_ff  <= s6_v3_in;
         s6_x5_ff  <= s5_x5_ff;
         s6_x2_ff  <= s5_x2_ff;
         s7_b1_ff  <= s7_b1_in;
         s7_a2_ff  <= s7_a2_in;
         s8_w1_ff  <= s8_w1_in;
         s8_n0_ff  <= s8_n0_in;
         s9_pd_ff  <= s9_pd_in;
         s9_wn_ff  <= s9_wn_in;
         s10_v1_ff <= s10_v1_in;
         s10_nm_ff <= s10_nm_in;
         s11_nm_ff <= s11_nm_in;
         s11_dm_ff <= s11_dm_in;
         q0_p_ff   <= q0_p_in;
         q1_p_ff   <= q0_p_ff;
         q1_x_ff   <= q1_x_in;
         q1_w9_ff  <= q1_w9_in;
         q1_w8_ff  <= q1_w8_in;
         q2_p_ff   <= q1_p_ff;
         q2_x_ff   <= q1_x_ff;
         q2_y_ff   <= q2_y_in;
         q2_pb_ff  <= q2_pb_in;
         q3_p_ff   <= q2_p_ff;
         q3_b2_ff  <= q3_b2_in;
         q3_wy_ff  <= q3_wy_in;
         q4_p_ff   <= q3_p_ff;
         q4_b2_ff  <= q3_b2_ff;
         q4_a3_ff  <= q4_a3_in;
         q5_s_ff   <= q5_s_in;
         out_ff    <= out_in;
      end
   end

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(pv_ff) && $stable(qv_ff))
      else $error("pipeline moved while stalled");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_ff.status == bsc_pkg::ST_OFFLINE ||
                      out_ff.status == bsc_pkg::ST_CALIB))
      |-> out_ff.temperature_centi == '0 && out_ff.pressure_q24_8 == '0)
      else $error("error result carries data");

endmodule

[sv/barometric_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation with held calibration words.
// Throughput: one reading per cycle while rsp_ready allows; the divider is a 64-stage pipeline.
// Synchronous active-high reset clears the calibration words, the valid flags
// and the queue; the block comes out of reset offline.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bsc_pkg::bsc_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bsc_pkg::bsc_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsc_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   logic                   online_ff, online_in;
   bsc_pkg::bsc_calib_type cal_ff, cal_in;
   logic                   fq_valid, fq_ready;
   bsc_pkg::bsc_item_type  fq_data;
   logic                   qb_valid, qb_ready;
   bsc_pkg::bsc_item_type  qb_data;

   always_comb begin
      online_in = online_ff;
      cal_in    = cal_ff;
      if (csr_we) begin
         case (csr_index)
            bsc_pkg::CSR_ONLINE:     online_in    = csr_wdata[0];
            bsc_pkg::CSR_TEMP_CALIB: cal_in.tcal  = csr_wdata[47:0];
            bsc_pkg::CSR_PRESS_LOW:  cal_in.plo   = csr_wdata;
            bsc_pkg::CSR_PRESS_HIGH: cal_in.phi   = csr_wdata;
            bsc_pkg::CSR_PRESS_LAST: cal_in.plast = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         online_ff <= 1'b0;
         cal_ff    <= '0;
      end else begin
         online_ff <= online_in;
         cal_ff    <= cal_in;
      end
   end

   bsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .online    (online_ff),
      .t1        (cal_ff.tcal[15:0]),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_data    (fq_data)
   );

   bsc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   bsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_data   (qb_data),
      .cal       (cal_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/tb_barometric_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// tb_barometric_sensor_compensation
// Drives raw pressure/temperature beats through the compensation block under
// several calibration settings and compares every result beat with an
// integer model of the 64-bit compensation computed in the bench.
// ----------------------------------------------------------------------------
module tb_barometric_sensor_compensation;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 84;
   localparam int STALL_LIMIT = 20000;
   localparam logic [bsc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   bsc_pkg::bsc_req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   bsc_pkg::bsc_rsp_type rsp_data;
   logic csr_we;
   logic [bsc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bsc_pkg::CSR_DAT_W-1:0] csr_wdata;

   barometric_sensor_compensation dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [63:0] online_r, tcal_r, plo_r, phi_r, plast_r;
   bsc_pkg::bsc_rsp_type expected_q[$];
   int errors = 0;
   int idle_cycles = 0;
   int send_pct = 37;
   int recv_pct = 37;
   bit recv_hold = 0;

   typedef struct {
      logic [19:0] praw;
      logic [19:0] traw;
      bit          known;
      bsc_pkg::bsc_rsp_type rsp;
   } vector_type;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] sx(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sra(logic [63:0] v, int n);
      return $signed(v) >>> n;
   endfunction

   function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic bsc_pkg::bsc_rsp_type compensate(logic [19:0] praw,
                                                        logic [19:0] traw);
      bsc_pkg::bsc_rsp_type r;
      logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] a, b, d, tfine, tc, p, press;
      t1 = {48'b0, tcal_r[15:0]};
      t2 = sx(tcal_r[31:16]);
      t3 = sx(tcal_r[47:32]);
      p1 = {48'b0, plo_r[15:0]};
      p2 = sx(plo_r[31:16]);
      p3 = sx(plo_r[47:32]);
      p4 = sx(plo_r[63:48]);
      p5 = sx(phi_r[15:0]);
      p6 = sx(phi_r[31:16]);
      p7 = sx(phi_r[47:32]);
      p8 = sx(phi_r[63:48]);
      p9 = sx(plast_r[15:0]);
      r.temperature_centi = '0;
      r.pressure_q24_8 = '0;
      if (online_r[0] == 0) begin
         r.status = bsc_pkg::ST_OFFLINE;
         return r;
      end
      if (t1 == 0) begin
         r.status = bsc_pkg::ST_CALIB;
         return r;
      end
      a = sra((({44'b0, traw} >> 3) - (t1 << 1)) * t2, 11);
      d = ({44'b0, traw} >> 4) - t1;
      b = sra(sra(d * d, 12) * t3, 14);
      tfine = a + b;
      tc = sra(tfine * 5 + 128, 8);
      if ($signed(tc) < -32768) tc = -64'sd32768;
      else if ($signed(tc) > 32767) tc = 64'd32767;
      r.temperature_centi = tc[15:0];
      a = tfine - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = sra(a * a * p3, 8) + ((a * p2) << 12);
      a = sra(((64'd1 << 47) + a) * p1, 33);
      if (a == 0) begin
         r.status = bsc_pkg::ST_ZERODIV;
         return r;
      end
      p = 64'd1048576 - {44'b0, praw};
      p = div_trunc(((p << 31) - b) * 64'd3125, a);
      a = sra(p9 * sra(p, 13) * sra(p, 13), 25);
      b = sra(p8 * p, 19);
      press = sra(p + a + b, 8) + (p7 << 4);
      if (press[63]) press = '0;
      else if (press > 64'hFFFF_FFFF) press = 64'hFFFF_FFFF;
      r.pressure_q24_8 = press[31:0];
      r.status = bsc_pkg::ST_OK;
      return r;
   endfunction

   task automatic csr_write(logic [bsc_pkg::CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         bsc_pkg::CSR_ONLINE:     online_r = val & 64'd1;
         bsc_pkg::CSR_TEMP_CALIB: tcal_r = val & 64'hFFFF_FFFF_FFFF;
         bsc_pkg::CSR_PRESS_LOW:  plo_r = val;
         bsc_pkg::CSR_PRESS_HIGH: phi_r = val;
         bsc_pkg::CSR_PRESS_LAST: plast_r = val & 64'hFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 0;
      csr_index <= bsc_pkg::CSR_IDX_W'($urandom);
      csr_wdata <= {$urandom, $urandom};
   endtask

   // called at a falling edge right after the last send
   task automatic drain();
      req_valid <= 0;
      req_data <= 40'({$urandom, $urandom});
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // typical calibration words, with optional random offsets on some fields
   task automatic typical_calib(bit jitter);
      logic [15:0] j;
      j = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
      csr_write(bsc_pkg::CSR_TEMP_CALIB,
                64'({16'hFC18, 16'd26435 + j, 16'd27504 + j}));
      csr_write(bsc_pkg::CSR_PRESS_LOW,
                {16'd2855, 16'hD0D0 + j, 16'hDF2E, 16'd36477 + j});
      csr_write(bsc_pkg::CSR_PRESS_HIGH, {16'd15500, 16'hC1D0, 16'hFFF9, 16'd140 + j});
      csr_write(bsc_pkg::CSR_PRESS_LAST, {48'b0, 16'd6000 + j});
   endtask

   // valid stays high after the beat so the next send can follow without a gap
   task automatic send(logic [19:0] praw, logic [19:0] traw, bit gaps);
      while (gaps && $urandom_range(0, 99) < send_pct) begin
         req_valid <= 0;
         req_data <= 40'({$urandom, $urandom});
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{press_code: praw, temp_code: traw};
      expected_q.push_back(compensate(praw, traw));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(int n);
      int k;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) < 8)
            send(20'($urandom_range(200000, 600000)), 20'($urandom_range(400000, 600000)), 1);
         else
            send(20'($urandom), 20'($urandom), 1);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result beat %h", rsp_data);
            errors++;
         end else begin
            bsc_pkg::bsc_rsp_type e;
            e = expected_q.pop_front();
            if (rsp_data.temperature_centi !== e.temperature_centi) begin
               $error("temperature_centi exp %0d got %0d",
                      e.temperature_centi, rsp_data.temperature_centi);
               errors++;
            end
            if (rsp_data.pressure_q24_8 !== e.pressure_q24_8) begin
               $error("pressure_q24_8 exp %0d got %0d", e.pressure_q24_8, rsp_data.pressure_q24_8);
               errors++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || recv_hold) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      vector_type dir[$];
      vector_type v;
      int i;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      online_r = 0; tcal_r = 0; plo_r = 0; phi_r = 0; plast_r = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // after reset: offline, fields zero
      v = '{20'hFFFFF, 20'h0, 1, '{16'sd0, 32'd0, bsc_pkg::ST_OFFLINE}}; dir.push_back(v);
      v = '{20'h0, 20'hFFFFF, 1, '{16'sd0, 32'd0, bsc_pkg::ST_OFFLINE}}; dir.push_back(v);
      foreach (dir[k]) begin
         send(dir[k].praw, dir[k].traw, 0);
         void'(expected_q.pop_back());
         expected_q.push_back(dir[k].rsp);
      end
      drain();
      csr_write(bsc_pkg::CSR_ONLINE, 64'd1);
      // online but T1 zero: calibration invalid
      send(20'h12345, 20'h54321, 0);
      drain();
      // T1 set, pressure coefficients zero: zero divisor
      csr_write(bsc_pkg::CSR_TEMP_CALIB, 64'({16'd0, 16'd26435, 16'd27504}));
      send(20'd415148, 20'd519888, 0);
      drain();
      typical_calib(0);
      dir.delete();
      v = '{20'd415148, 20'd519888, 0, '{16'sd0, 32'd0, bsc_pkg::ST_OK}}; dir.push_back(v);
      v = '{20'h00000, 20'h00000, 0, '{16'sd0, 32'd0, bsc_pkg::ST_OK}}; dir.push_back(v);
      v = '{20'hFFFFF, 20'hFFFFF, 0, '{16'sd0, 32'd0, bsc_pkg::ST_OK}}; dir.push_back(v);
      v = '{20'h00000, 20'hFFFFF, 0, '{16'sd0, 32'd0, bsc_pkg::ST_OK}}; dir.push_back(v);
      v = '{20'hFFFFF, 20'h00000, 0, '{16'sd0, 32'd0, bsc_pkg::ST_OK}}; dir.push_back(v);
      v = '{20'h80000, 20'h7FFFF, 0, '{16'sd0, 32'd0, bsc_pkg::ST_OK}}; dir.push_back(v);
      v = '{20'h55555, 20'hAAAAA, 0, '{16'sd0, 32'd0, bsc_pkg::ST_OK}}; dir.push_back(v);
      for (i = 0; i < dir.size(); i++) send(dir[i].praw, dir[i].traw, 0);
      drain();
      // extreme coefficients: saturation, clamping, sign extremes
      csr_write(bsc_pkg::CSR_TEMP_CALIB, 64'({16'h7FFF, 16'h7FFF, 16'hFFFF}));
      csr_write(bsc_pkg::CSR_PRESS_LOW, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF});
      csr_write(bsc_pkg::CSR_PRESS_HIGH, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      csr_write(bsc_pkg::CSR_PRESS_LAST, 64'hFFFF_FFFF_FFFF_8000);
      for (i = 0; i < dir.size(); i++) send(dir[i].praw, dir[i].traw, 0);
      drain();
      csr_write(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      send_random(40);
      drain();

      // long burst without idling, then receiver hold-off
      typical_calib(1);
      send_pct = 0; recv_pct = 0;
      send_random(200);
      fork
         begin
            recv_hold = 1;
            repeat (300) @(posedge clock);
            recv_hold = 0;
         end
         send_random(150);
      join
      send_pct = 37; recv_pct = 37;
      drain();

      for (i = 0; i < 6; i++) begin
         if (i % 3 == 0) begin
            csr_write(bsc_pkg::CSR_TEMP_CALIB, {$urandom, $urandom});
            csr_write(bsc_pkg::CSR_PRESS_LOW, {$urandom, $urandom});
            csr_write(bsc_pkg::CSR_PRESS_HIGH, {$urandom, $urandom});
            csr_write(bsc_pkg::CSR_PRESS_LAST, {$urandom, $urandom});
         end else begin
            typical_calib(1);
         end
         if (i == 4) csr_write(bsc_pkg::CSR_ONLINE, 64'd0);
         if (i == 5) csr_write(bsc_pkg::CSR_ONLINE, 64'd1);
         send_random(170);
         drain();
      end

      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
sv/bsc_pkg.sv
sv/bsc_front.sv
sv/bsc_fifo.sv
sv/bsc_div.sv
sv/bsc_back.sv
sv/barometric_sensor_compensation.sv
bench/tb_barometric_sensor_compensation.sv
